[hw/rtl/at_response_line_classifier_defines.svh]
// Shared assertion macros for the line classifier checks.
`ifndef AT_RESPONSE_LINE_CLASSIFIER_DEFINES_SVH
`define AT_RESPONSE_LINE_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ATRLC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("line classifier check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ATRLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("line classifier check failed");

`endif

[hw/rtl/atrlc_pkg.sv]
`timescale 1ns / 1ps
package atrlc_pkg;

	// Keyword set
	localparam int KW_COUNT   = 13;
	localparam int KW_MAX_LEN = 11;

	// Keywords left-justified, space padded; padding is never compared
	localparam logic [8*KW_MAX_LEN-1:0] KW_STR [KW_COUNT] = '{
		"OK         ",
		"ERROR      ",
		"+CME ERROR:",
		"+CMT:      ",
		"+CMTI:     ",
		"+CLIP:     ",
		"+CREG:     ",
		"+CGREG:    ",
		"+CEREG:    ",
		"+QIURC:    ",
		"+QIOPEN:   ",
		"+QIRD:     ",
		"+QICLOSE   "
	};

	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd2, 4'd5, 4'd11, 4'd5, 4'd6, 4'd6, 4'd6, 4'd7, 4'd7, 4'd7, 4'd8, 4'd6, 4'd8
	};

	// Keywords that must be the whole trimmed line (OK, ERROR)
	localparam logic [KW_COUNT-1:0] KW_EXACT = 13'h0003;

	// Keyword bit positions used by the class priority
	localparam int KW_OK   = 0;
	localparam int KW_ERR  = 1;
	localparam int KW_CME  = 2;
	localparam logic [KW_COUNT-1:0] KW_URC_MASK = 13'h1FF8;

	// Position counter
	localparam int         POS_W   = 4;
	localparam logic [3:0] POS_MAX = 4'hF;

	// Line classes
	localparam logic [2:0] CLS_OK   = 3'd0;
	localparam logic [2:0] CLS_ERR  = 3'd1;
	localparam logic [2:0] CLS_CME  = 3'd2;
	localparam logic [2:0] CLS_URC  = 3'd3;
	localparam logic [2:0] CLS_DATA = 3'd4;

	// Special characters
	localparam logic [7:0] CH_HT     = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_PROMPT = 8'h3E;

	typedef logic [KW_COUNT-1:0] kw_mask_t;

	// Character of keyword k at position pos (zero past the padded text)
	function automatic logic [7:0] kw_byte(input int k, input logic [POS_W-1:0] pos);
		int sel;
		sel = KW_MAX_LEN - 1 - int'(pos);
		if (int'(pos) < KW_MAX_LEN) begin
			return KW_STR[k][8*sel +: 8];
		end
		return 8'h00;
	endfunction

endpackage

[hw/rtl/atrlc_byte_if.sv]
`timescale 1ns / 1ps
// One received character per beat.
interface atrlc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

[hw/rtl/atrlc_line_if.sv]
`timescale 1ns / 1ps
// One line classification per beat.
interface atrlc_line_if;
	logic       valid;
	logic       ready;
	logic [2:0] line_class;
	logic       is_prompt;

	modport source (output valid, output line_class, output is_prompt, input ready);
	modport sink   (input valid, input line_class, input is_prompt, output ready);
endinterface

[hw/rtl/at_response_line_classifier.sv]
`timescale 1ns / 1ps
// Channel   Dir  Payload                         Beat
// char_ch   in   data_byte[7:0]                  one reply character
// line_ch   out  line_class[2:0], is_prompt      one ended line
//
// One character per cycle while not stalled: the keyword compares and class pick
// sit between the line state registers and the registered result.
// arst_n clears the line state and the result valid; the first line starts empty.
// A result waiting in the output register still lets a character in while the
// sink takes it; characters stall only while that result is held unread.
module at_response_line_classifier
	import atrlc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	atrlc_byte_if.sink    char_ch,
	atrlc_line_if.source  line_ch
);

	// Line state
	logic             line_empty_q;
	logic             started_q;
	logic [POS_W-1:0] pos_q;
	kw_mask_t         alive_q;
	kw_mask_t         hit_q;
	logic             prev_cr_q;

	// Result register
	logic             out_valid_q;
	logic [2:0]       out_class_q;
	logic             out_prompt_q;

	logic             accept;
	logic             is_ws;
	logic             prompt_line;
	logic             line_end;
	logic             emit;
	logic [2:0]       class_now;
	kw_mask_t         alive_d;
	kw_mask_t         hit_d;

	assign char_ch.ready = !out_valid_q || line_ch.ready;
	assign accept        = char_ch.valid && char_ch.ready;

	// Line end detection
	assign is_ws       = (char_ch.data_byte == CH_SPACE) ||
	                     (char_ch.data_byte >= CH_HT && char_ch.data_byte <= CH_CR);
	assign prompt_line = line_empty_q && (char_ch.data_byte == CH_PROMPT);
	assign line_end    = prev_cr_q && (char_ch.data_byte == CH_LF);
	assign emit        = prompt_line || line_end;

	// Class from hits, first match wins
	always_comb begin
		if (hit_q[KW_OK]) begin
			class_now = CLS_OK;
		end else if (hit_q[KW_ERR]) begin
			class_now = CLS_ERR;
		end else if (hit_q[KW_CME]) begin
			class_now = CLS_CME;
		end else if ((hit_q & KW_URC_MASK) != '0) begin
			class_now = CLS_URC;
		end else begin
			class_now = CLS_DATA;
		end
	end

	// Parallel keyword compare at the current position
	always_comb begin
		alive_d = alive_q;
		hit_d   = hit_q;
		for (int k = 0; k < KW_COUNT; k++) begin
			if (alive_q[k]) begin
				if (pos_q < KW_LEN[k]) begin
					if (kw_byte(k, pos_q) != char_ch.data_byte) begin
						alive_d[k] = 1'b0;
					end else if (({1'b0, pos_q} + 5'd1) == {1'b0, KW_LEN[k]}) begin
						hit_d[k] = 1'b1;
					end
				end else if (KW_EXACT[k] && !is_ws) begin
					// trailing text after OK/ERROR cancels it
					alive_d[k] = 1'b0;
					hit_d[k]   = 1'b0;
				end
			end
		end
	end

	// Line state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_empty_q <= 1'b1;
			started_q    <= 1'b0;
			pos_q        <= '0;
			alive_q      <= '1;
			hit_q        <= '0;
			prev_cr_q    <= 1'b0;
		end else if (accept) begin
			if (emit) begin
				line_empty_q <= 1'b1;
				started_q    <= 1'b0;
				pos_q        <= '0;
				alive_q      <= '1;
				hit_q        <= '0;
				prev_cr_q    <= 1'b0;
			end else begin
				line_empty_q <= 1'b0;
				if (started_q || !is_ws) begin
					started_q <= 1'b1;
					alive_q   <= alive_d;
					hit_q     <= hit_d;
					if (pos_q != POS_MAX) begin
						pos_q <= pos_q + 4'd1;
					end
				end
				prev_cr_q <= (char_ch.data_byte == CH_CR);
			end
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && emit) begin
			out_valid_q <= 1'b1;
		end else if (line_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (accept && emit) begin
			out_class_q  <= prompt_line ? CLS_DATA : class_now;
			out_prompt_q <= prompt_line;
		end
	end

	assign line_ch.valid      = out_valid_q;
	assign line_ch.line_class = out_class_q;
	assign line_ch.is_prompt  = out_prompt_q;

endmodule

[hw/rtl/atrlc_checker.sv]
`timescale 1ns / 1ps
`include "at_response_line_classifier_defines.svh"
// Port-level checks for the line classifier.
module atrlc_checker
	import atrlc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	atrlc_byte_if.sink    char_ch,
	atrlc_line_if.source  line_ch
);

	// held result keeps its payload
	`ATRLC_ASSERT_NEXT(a_out_hold, clk, arst_n, line_ch.valid && !line_ch.ready, line_ch.valid && $stable(line_ch.line_class) && $stable(line_ch.is_prompt))

	// prompt lines always report intermediate data
	`ATRLC_ASSERT_NOW(a_prompt_class, clk, arst_n, line_ch.valid && line_ch.is_prompt, line_ch.line_class == CLS_DATA)

	// class code stays in range
	`ATRLC_ASSERT_NOW(a_class_range, clk, arst_n, line_ch.valid, line_ch.line_class <= CLS_DATA)

	// input is never stalled while no result is pending
	`ATRLC_ASSERT_NOW(a_ready_free, clk, arst_n, !line_ch.valid, char_ch.ready)

endmodule

bind at_response_line_classifier atrlc_checker u_atrlc_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.char_ch (char_ch),
	.line_ch (line_ch)
);
